// ----- sv/snet_pkg.sv -----
package snet_pkg;

   localparam int CAPACITY = 256;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LANE_W   = 4;
   localparam int LANES    = 1 << LANE_W;
   localparam int ROWS     = (CAPACITY + LANES - 1) / LANES;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   typedef struct packed {
      logic [30:0] start_sample;
      logic [30:0] length_samples;
      logic [6:0]  note_number;
   } entry_type;

   typedef struct packed {
      logic        action;
      logic [30:0] start_sample;
      logic [30:0] length_samples;
      logic [6:0]  note_number;
      logic [7:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [30:0] entry_start;
      logic [30:0] entry_length;
      logic [6:0]  entry_note;
      logic        entry_valid;
      logic [8:0]  event_count;
      logic [31:0] last_end_sample;
      logic        insert_dropped;
   } rsp_type;

   typedef struct packed {
      logic      shift_en;
      entry_type item;
   } cell_ctrl_type;

endpackage

// ----- sv/sorted_note_event_table_unit.sv -----
// channel   ports                     handshake
// request   start, busy, req_data     taken when start is high and busy is low
// response  rsp_strobe, rsp_data      one cycle per item, no back-pressure
//
// an insert that finds room updates the whole cell row; its item appears the next cycle
// and a new item may follow at once
// a read goes through a two-level registered select; busy is high for one cycle and
// the item appears once it has passed the row register and the response register
// synchronous reset empties the table; cell contents are not cleared
module sorted_note_event_table_unit import snet_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic {IDLE, READ} state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      last_end_ff;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff;
   entry_type        row_ff [ROWS];
   logic [ROW_W-1:0] row_sel_ff;
   logic             rd_valid_ff;

   cell_ctrl_type    ctrl;
   entry_type        entries [CAPACITY];
   logic             appended;
   logic             accept;
   logic             full;
   logic             do_insert;
   logic [CNT_W-1:0] count_in;
   logic [31:0]      last_end_in;
   logic [7:0]       rd_idx;
   entry_type        row_in [ROWS];
   entry_type        rd_entry;

   assign accept    = start && (state_ff == IDLE);
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign do_insert = accept && (req_data.action == ACT_INSERT) && !full;
   assign rd_idx    = req_data.read_index;

   assign ctrl.shift_en                = do_insert;
   assign ctrl.item.start_sample       = req_data.start_sample;
   assign ctrl.item.length_samples     = req_data.length_samples;
   assign ctrl.item.note_number        = req_data.note_number;

   snet_chain u_chain (
      .clock    (clock),
      .ctrl     (ctrl),
      .count    (count_ff),
      .entries  (entries),
      .appended (appended)
   );

   assign count_in    = do_insert ? count_ff + CNT_W'(1) : count_ff;
   assign last_end_in = (do_insert && appended)
                      ? {1'b0, req_data.start_sample} + {1'b0, req_data.length_samples}
                      : last_end_ff;

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         row_in[r] = entries[IDX_W'((r * LANES + int'(rd_idx[LANE_W-1:0])) % CAPACITY)];
      end
   end

   assign rd_entry = row_ff[row_sel_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         last_end_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         last_end_ff   <= last_end_in;
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  if (req_data.action == ACT_INSERT) begin
                     rsp_strobe_ff <= 1'b1;
                  end else begin
                     state_ff <= READ;
                  end
               end
            end
            READ: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_data.action == ACT_READ)) begin
         row_ff      <= row_in;
         row_sel_ff  <= ROW_W'(rd_idx >> LANE_W);
         rd_valid_ff <= CNT_W'(rd_idx) < count_ff;
      end
      if (accept && (req_data.action == ACT_INSERT)) begin
         rsp_ff.entry_start     <= '0;
         rsp_ff.entry_length    <= '0;
         rsp_ff.entry_note      <= '0;
         rsp_ff.entry_valid     <= 1'b0;
         rsp_ff.event_count     <= 9'(count_in);
         rsp_ff.last_end_sample <= last_end_in;
         rsp_ff.insert_dropped  <= full;
      end else if (state_ff == READ) begin
         rsp_ff.entry_start     <= rd_valid_ff ? rd_entry.start_sample : '0;
         rsp_ff.entry_length    <= rd_valid_ff ? rd_entry.length_samples : '0;
         rsp_ff.entry_note      <= rd_valid_ff ? rd_entry.note_number : '0;
         rsp_ff.entry_valid     <= rd_valid_ff;
         rsp_ff.event_count     <= 9'(count_ff);
         rsp_ff.last_end_sample <= last_end_ff;
         rsp_ff.insert_dropped  <= 1'b0;
      end
   end

   assign busy       = state_ff == READ;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("event count above capacity");

   a_busy_quiet: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("item delivered while read in flight");

   a_insert_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action == ACT_INSERT) |=> rsp_strobe)
      else $error("insert item missing");

   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action == ACT_READ) |-> ##2 rsp_strobe)
      else $error("read item missing");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.insert_dropped) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("drop flagged with room left");

endmodule

// ----- sv/snet_cell.sv -----
module snet_cell import snet_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          prev_lt,
   input  entry_type     prev_entry,
   output logic          lt,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;

   assign lt    = occupied && (entry_ff.start_sample < ctrl.item.start_sample);
   assign entry = entry_ff;

   always_comb begin
      priority if (lt) begin
         entry_in = entry_ff;
      end else if (prev_lt) begin
         entry_in = ctrl.item;
      end else begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ----- sv/snet_chain.sv -----
module snet_chain import snet_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0] count,
   output entry_type     entries [CAPACITY],
   output logic          appended
);

   logic [CAPACITY-1:0] occupied;
   logic [CAPACITY-1:0] lt;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         assign occupied[i] = CNT_W'(i) < count;
         if (i == 0) begin : g_head
            snet_cell u_cell (
               .clock      (clock),
               .ctrl       (ctrl),
               .occupied   (occupied[i]),
               .prev_lt    (1'b1),
               .prev_entry (ctrl.item),
               .lt         (lt[i]),
               .entry      (entries[i])
            );
         end else begin : g_body
            snet_cell u_cell (
               .clock      (clock),
               .ctrl       (ctrl),
               .occupied   (occupied[i]),
               .prev_lt    (lt[i-1]),
               .prev_entry (entries[i-1]),
               .lt         (lt[i]),
               .entry      (entries[i])
            );
         end
      end
   endgenerate

   // new item lands after every stored entry
   assign appended = ~|(occupied & ~lt);

endmodule
